// ===== hw/rtl/greedy_rectangle_merge_assert.svh =====
// assertion macros used by the checker of the greedy rectangle merge block
`ifndef GREEDY_RECTANGLE_MERGE_ASSERT_SVH
`define GREEDY_RECTANGLE_MERGE_ASSERT_SVH

// same-cycle implication, checked on i_clk, off while i_rst_n is low
`define GRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grm same-cycle check failed");

// next-cycle implication, checked on i_clk, off while i_rst_n is low
`define GRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grm next-cycle check failed");

`endif

// ===== hw/rtl/grm_pkg.sv =====
`default_nettype none

package grm_pkg;

    localparam int VALUE_W   = 24;
    localparam int COORD_W   = 4;
    localparam int SIZE_W    = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_USED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_USED = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_USED_RST  = 5'd16;
    localparam logic [CFG_W-1:0] HEIGHT_USED_RST = 5'd16;

    // input action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] cell_u;
        logic [COORD_W-1:0] cell_v;
        logic [VALUE_W-1:0] cell_value;
    } t_in;

    typedef struct packed {
        logic               rect_found;
        logic [COORD_W-1:0] rect_u;
        logic [COORD_W-1:0] rect_v;
        logic [SIZE_W-1:0]  rect_du;
        logic [SIZE_W-1:0]  rect_dv;
        logic [VALUE_W-1:0] rect_value;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RUN,
        ST_DOWN,
        ST_ERASE,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_LOAD,
        OP_FETCH,
        OP_SCAN,
        OP_RUN,
        OP_DOWN,
        OP_ERASE,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic clear_done;
        logic scan_hit;
        logic scan_miss;
        logic run_stop;
        logic down_stop;
        logic erase_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/greedy_rectangle_merge.sv =====
// channel   direction  handshake                payload
// input     in         i_in_valid / o_in_stall  i_in_data  (t_in: action, cell, value)
// output    out        o_out_valid / i_out_stall o_out_data (t_out: rectangle or done)
// config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// a load writes its cell into the mask when it lies inside the used area; a fetch keeps the
// input stalled while it scans and, on a hit, runs, checks rows down and erases, then emits,
// its pace set by the single read port and single write port of the mask memory; after reset
// a clearing pass zeroes the mask while the input stays stalled; config writes still land;
// a finished result waits in the output register, so loads keep flowing under output stall;
// a fetch that finishes while that register is full waits for it to drain

`default_nettype none

module greedy_rectangle_merge
    import grm_pkg::*;
#(
    parameter int MAX_COLUMNS = 16,
    parameter int MAX_ROWS    = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input transactions: mask loads and rectangle fetches
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire t_in                  i_in_data,
    // output transactions: one per fetch
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      t_out                 o_out_data,
    // register writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_op   dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: clear pass, then scan / run / down / erase / emit per fetch (a scan miss goes straight to emit)
    grm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_stat     (dp_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    // mask memory, walk counters, rectangle registers and output register
    grm_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_stat      (dp_stat)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/grm_ram.sv =====
`default_nettype none

module grm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/grm_ctrl.sv =====
`default_nettype none

module grm_ctrl
    import grm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_action,
    input  wire t_dp_stat i_stat,
    output      logic     o_in_stall,
    output      t_dp_op   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = OP_IDLE;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd = OP_CLEAR;
                if (i_stat.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_action == ACT_LOAD) begin
                        o_cmd = OP_LOAD;
                    end else begin
                        o_cmd   = OP_FETCH;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd = OP_SCAN;
                if (i_stat.scan_hit) begin
                    n_state = ST_RUN;
                end else if (i_stat.scan_miss) begin
                    n_state = ST_EMIT;
                end
            end
            ST_RUN: begin
                o_cmd = OP_RUN;
                if (i_stat.run_stop) begin
                    n_state = ST_DOWN;
                end
            end
            ST_DOWN: begin
                o_cmd = OP_DOWN;
                if (i_stat.down_stop) begin
                    n_state = ST_ERASE;
                end
            end
            ST_ERASE: begin
                o_cmd = OP_ERASE;
                if (i_stat.erase_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd = OP_EMIT;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/grm_dp.sv =====
`default_nettype none

module grm_dp
    import grm_pkg::*;
#(
    parameter int MAX_COLUMNS = 16,
    parameter int MAX_ROWS    = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_op               i_cmd,
    input  wire t_in                  i_in_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_out_stall,
    output      logic                 o_out_valid,
    output      t_out                 o_out_data,
    output      t_dp_stat             o_stat
);

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CNW   = $clog2(MAX_COLUMNS + 1);
    localparam int RNW   = $clog2(MAX_ROWS + 1);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int XCW   = (CNW > CFG_W) ? CNW : CFG_W;
    localparam int XRW   = (RNW > CFG_W) ? RNW : CFG_W;

    // configuration
    logic [CFG_W-1:0]   r_width_used;
    logic [CFG_W-1:0]   r_height_used;

    // control registers
    logic [AW-1:0]      r_clr;
    logic               r_pv;
    logic [RNW-1:0]     r_sr;
    logic [CNW-1:0]     r_sc;
    logic               r_out_valid;

    // walk and result registers
    logic [RNW-1:0]     r_ir;
    logic [CNW-1:0]     r_ic;
    logic               r_plast;
    logic [RNW-1:0]     r_pr;
    logic [CNW-1:0]     r_pc;
    logic [RNW-1:0]     r_r0;
    logic [CNW-1:0]     r_c0;
    logic [CNW-1:0]     r_du;
    logic [RNW-1:0]     r_dv;
    logic [VALUE_W-1:0] r_val;
    logic               r_found;
    t_out               r_out;

    logic [AW-1:0]      n_clr;
    logic               n_pv;
    logic [RNW-1:0]     n_sr;
    logic [CNW-1:0]     n_sc;
    logic               n_out_valid;
    logic [RNW-1:0]     n_ir;
    logic [CNW-1:0]     n_ic;
    logic               n_plast;
    logic [RNW-1:0]     n_pr;
    logic [CNW-1:0]     n_pc;
    logic [RNW-1:0]     n_r0;
    logic [CNW-1:0]     n_c0;
    logic [CNW-1:0]     n_du;
    logic [RNW-1:0]     n_dv;
    logic [VALUE_W-1:0] n_val;
    logic               n_found;
    t_out               n_out;

    logic [CNW-1:0]     eff_w;
    logic [RNW-1:0]     eff_h;
    logic [CNW-1:0]     ic_inc;
    logic [RNW-1:0]     ir_inc;
    logic [CNW-1:0]     col_end;
    logic [RNW-1:0]     row_end;
    logic               ic_lt_w;
    logic               ir_lt_h;
    logic               rd_eq;
    logic               load_ok;
    logic               out_free;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    grm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // used area, clamped to the store size
    assign eff_w = (XCW'(r_width_used) > XCW'(MAX_COLUMNS)) ? CNW'(MAX_COLUMNS)
                                                             : CNW'(r_width_used);
    assign eff_h = (XRW'(r_height_used) > XRW'(MAX_ROWS)) ? RNW'(MAX_ROWS)
                                                          : RNW'(r_height_used);

    assign ic_inc  = r_ic + CNW'(1);
    assign ir_inc  = r_ir + RNW'(1);
    assign col_end = r_c0 + r_du;
    assign row_end = r_r0 + r_dv;
    assign ic_lt_w = r_ic < eff_w;
    assign ir_lt_h = r_ir < eff_h;
    assign rd_eq   = mem_rdata == r_val;
    assign load_ok = (XCW'(i_in_data.cell_u) < XCW'(eff_w))
                  && (XRW'(i_in_data.cell_v) < XRW'(eff_h));
    assign out_free = !r_out_valid || !i_out_stall;

    assign mem_raddr = {r_ir[RW-1:0], r_ic[CW-1:0]};

    assign o_stat.clear_done = &r_clr;
    assign o_stat.scan_hit   = r_pv && (mem_rdata != '0);
    assign o_stat.scan_miss  = !(r_pv && (mem_rdata != '0)) && !ir_lt_h;
    assign o_stat.run_stop   = r_pv ? !rd_eq : !ic_lt_w;
    assign o_stat.down_stop  = r_pv ? !rd_eq : !ir_lt_h;
    assign o_stat.erase_done = (ic_inc == col_end) && (ir_inc == row_end);
    assign o_stat.out_free   = out_free;

    always_comb begin
        n_clr       = r_clr;
        n_pv        = r_pv;
        n_sr        = r_sr;
        n_sc        = r_sc;
        n_ir        = r_ir;
        n_ic        = r_ic;
        n_plast     = r_plast;
        n_pr        = r_pr;
        n_pc        = r_pc;
        n_r0        = r_r0;
        n_c0        = r_c0;
        n_du        = r_du;
        n_dv        = r_dv;
        n_val       = r_val;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = {r_ir[RW-1:0], r_ic[CW-1:0]};
        mem_wdata   = '0;
        unique case (i_cmd)
            OP_IDLE: begin
            end
            OP_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
            end
            OP_LOAD: begin
                mem_we    = load_ok;
                mem_waddr = {RW'(i_in_data.cell_v), CW'(i_in_data.cell_u)};
                mem_wdata = i_in_data.cell_value;
                n_sr      = '0;
                n_sc      = '0;
            end
            OP_FETCH: begin
                n_ir = r_sr;
                n_ic = r_sc;
                n_pv = 1'b0;
            end
            OP_SCAN: begin
                if (r_pv && (mem_rdata != '0)) begin
                    // first nonzero cell: it becomes the origin
                    n_r0    = r_pr;
                    n_c0    = r_pc;
                    n_val   = mem_rdata;
                    n_found = 1'b1;
                    n_du    = CNW'(1);
                    n_ir    = r_pr;
                    n_ic    = r_pc + CNW'(1);
                    n_pv    = 1'b0;
                end else if (!ir_lt_h) begin
                    n_found = 1'b0;
                    n_pv    = 1'b0;
                end else if (ic_lt_w) begin
                    n_pr = r_ir;
                    n_pc = r_ic;
                    n_pv = 1'b1;
                    if (ic_inc >= eff_w) begin
                        n_ir = ir_inc;
                        n_ic = '0;
                    end else begin
                        n_ic = ic_inc;
                    end
                end else begin
                    n_ir = ir_inc;
                    n_ic = '0;
                    n_pv = 1'b0;
                end
            end
            OP_RUN: begin
                if (r_pv && rd_eq) begin
                    n_du = r_du + CNW'(1);
                end
                if (r_pv ? !rd_eq : !ic_lt_w) begin
                    n_ir = r_r0 + RNW'(1);
                    n_ic = r_c0;
                    n_dv = RNW'(1);
                    n_pv = 1'b0;
                end else if (ic_lt_w) begin
                    n_pv = 1'b1;
                    n_ic = ic_inc;
                end else begin
                    n_pv = 1'b0;
                end
            end
            OP_DOWN: begin
                // a row counts once its last cell has matched
                if (r_pv && rd_eq && r_plast) begin
                    n_dv = r_dv + RNW'(1);
                end
                if (r_pv ? !rd_eq : !ir_lt_h) begin
                    n_ir = r_r0;
                    n_ic = r_c0;
                    n_pv = 1'b0;
                end else if (ir_lt_h) begin
                    n_pv    = 1'b1;
                    n_plast = ic_inc == col_end;
                    if (ic_inc == col_end) begin
                        n_ir = ir_inc;
                        n_ic = r_c0;
                    end else begin
                        n_ic = ic_inc;
                    end
                end else begin
                    n_pv = 1'b0;
                end
            end
            OP_ERASE: begin
                mem_we = 1'b1;
                if (ic_inc == col_end) begin
                    n_ir = ir_inc;
                    n_ic = r_c0;
                end else begin
                    n_ic = ic_inc;
                end
                if ((ic_inc == col_end) && (ir_inc == row_end)) begin
                    n_sr = r_r0;
                    n_sc = r_c0;
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_found) begin
                        n_out.rect_found = 1'b1;
                        n_out.rect_u     = COORD_W'(r_c0);
                        n_out.rect_v     = COORD_W'(r_r0);
                        n_out.rect_du    = SIZE_W'(r_du);
                        n_out.rect_dv    = SIZE_W'(r_dv);
                        n_out.rect_value = r_val;
                    end else begin
                        n_out = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_used  <= WIDTH_USED_RST;
            r_height_used <= HEIGHT_USED_RST;
            r_clr         <= '0;
            r_pv          <= 1'b0;
            r_sr          <= '0;
            r_sc          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WIDTH_USED:  r_width_used  <= i_cfg_data;
                    CFG_HEIGHT_USED: r_height_used <= i_cfg_data;
                endcase
            end
            r_clr       <= n_clr;
            r_pv        <= n_pv;
            r_sr        <= n_sr;
            r_sc        <= n_sc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ir    <= n_ir;
        r_ic    <= n_ic;
        r_plast <= n_plast;
        r_pr    <= n_pr;
        r_pc    <= n_pc;
        r_r0    <= n_r0;
        r_c0    <= n_c0;
        r_du    <= n_du;
        r_dv    <= n_dv;
        r_val   <= n_val;
        r_found <= n_found;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/grm_checker.sv =====
`default_nettype none

`include "greedy_rectangle_merge_assert.svh"

module grm_checker
    import grm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 o_in_stall,
    input  wire t_in                  i_in_data,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire t_out                 o_out_data
);

    logic in_take;
    logic rect_sane;

    assign in_take   = i_in_valid && !o_in_stall;
    assign rect_sane = (o_out_data.rect_du != '0) && (o_out_data.rect_dv != '0)
                    && (o_out_data.rect_value != '0);

    // a stalled result holds
    `GRM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // a done report carries all-zero fields
    `GRM_ASSERT_NOW(a_done_zero, o_out_valid && !o_out_data.rect_found, o_out_data == '0)

    // a rectangle is never empty and never of empty cells
    `GRM_ASSERT_NOW(a_rect_nonempty, o_out_valid && o_out_data.rect_found, rect_sane)

    // a fetch holds off the input while it works
    `GRM_ASSERT_NEXT(a_fetch_busy, in_take && i_in_data.action == ACT_FETCH, o_in_stall)

    // a load leaves the input unstalled in the next cycle
    `GRM_ASSERT_NEXT(a_load_single, in_take && i_in_data.action == ACT_LOAD, !o_in_stall)

endmodule

bind greedy_rectangle_merge grm_checker u_grm_checker (.*);

`default_nettype wire
